// ===== sv/mm4_pkg.sv =====
package mm4_pkg;

  localparam int DIM_DEF       = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int VALUE_W       = 32;
  localparam int INDEX_W       = 2;

  localparam logic MODE_CUR = 1'b0;
  localparam logic MODE_OPR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_EMIT
  } mm4_state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic first;
    logic emit;
    logic last_elem;
    logic busy;
  } mm4_ctrl_t;

endpackage

// ===== sv/matrix4_multiply_accumulate.sv =====
// Element write: taken when not busy, busy stays low; the receiver cannot stall results.
// Commit (mode 1 with last): busy until the final result; each row copies DIM current
// elements into a row buffer, then for each product element issues DIM products,
// drains through DRAIN1 and DRAIN2 and emits the result in EMIT, row by row.
// Reset: synchronous; current matrix returns to identity, operand matrix is not cleared.
module matrix4_multiply_accumulate import mm4_pkg::*; #(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode,
  input  logic [INDEX_W-1:0]        row,
  input  logic [INDEX_W-1:0]        col,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last,
  output logic                      out_valid,
  output logic [INDEX_W-1:0]        out_row,
  output logic [INDEX_W-1:0]        out_col,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_last
);

  localparam int IW     = $clog2(DIM);
  localparam int CIDX_W = $clog2(DIM * DIM);
  localparam logic [VALUE_W-1:0] ONE = VALUE_W'(1) << FRAC_BITS;

  mm4_ctrl_t                 ctrl;
  logic [IW-1:0]             i, j, k;
  logic                      accept, in_range, commit;
  logic [CIDX_W-1:0]         wr_idx, cur_rd_idx, op_rd_idx, wb_idx;
  logic signed [VALUE_W-1:0] cur [DIM*DIM];
  logic signed [VALUE_W-1:0] rowbuf [DIM];
  logic signed [VALUE_W-1:0] op_rdata;
  logic signed [VALUE_W-1:0] sat_value;

  assign accept   = start && !busy;
  assign in_range = (int'(row) < DIM) && (int'(col) < DIM);
  assign commit   = accept && (mode == MODE_OPR) && last;

  assign wr_idx     = CIDX_W'(int'(row) * DIM + int'(col));
  assign cur_rd_idx = CIDX_W'(int'(i) * DIM + int'(k));
  assign op_rd_idx  = CIDX_W'(int'(k) * DIM + int'(j));
  assign wb_idx     = CIDX_W'(int'(i) * DIM + int'(j));

  mm4_seq #(.DIM(DIM)) u_seq (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .ctrl   (ctrl),
    .i      (i),
    .j      (j),
    .k      (k)
  );

  mm4_ram #(.WIDTH(VALUE_W), .DEPTH(DIM * DIM)) u_opr (
    .clk   (clk),
    .we    (accept && (mode == MODE_OPR) && in_range),
    .waddr (wr_idx),
    .wdata (value),
    .raddr (op_rd_idx),
    .rdata (op_rdata)
  );

  mm4_mac #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (ctrl.issue),
    .first     (ctrl.first),
    .a         (rowbuf[k]),
    .b         (op_rdata),
    .sat_value (sat_value)
  );

  // current matrix: input writes while idle, product write-back while committing
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          cur[r*DIM + c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (accept && (mode == MODE_CUR) && in_range) begin
      cur[wr_idx] <= value;
    end else if (ctrl.emit) begin
      cur[wb_idx] <= sat_value;
    end
  end

  // hold row i so write-back of row i cannot disturb its own products
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rowbuf[k] <= cur[cur_rd_idx];
    end
  end

  assign busy      = ctrl.busy;
  assign out_valid = ctrl.emit;
  assign out_row   = INDEX_W'(i);
  assign out_col   = INDEX_W'(j);
  assign out_value = sat_value;
  assign out_last  = ctrl.last_elem;

`ifndef SYNTHESIS
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy)
    else $error("result strobe outside a commit");

  a_commit_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_OPR && last) |=> busy)
    else $error("commit did not start");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |=> !busy)
    else $error("still busy after final result");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |=> (busy && !out_valid))
    else $error("results not separated by accumulate cycles");
`endif

endmodule

// ===== sv/mm4_ram.sv =====
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mm4_mac.sv =====
module mm4_mac import mm4_pkg::*; #(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      issue,
  input  logic                      first,
  input  logic signed [VALUE_W-1:0] a,
  input  logic signed [VALUE_W-1:0] b,
  output logic signed [VALUE_W-1:0] sat_value
);

  localparam int PROD_W = 2 * VALUE_W;
  localparam int ACC_W  = PROD_W - FRAC_BITS + $clog2(DIM);

  logic                      v1, f1, v2, f2;
  logic signed [VALUE_W-1:0] a_q;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   shifted;
  logic                      in_range;

  // b comes registered from the operand RAM after issue; register a to align with it
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    a_q  <= a;
    f1   <= first;
    f2   <= f1;
    prod <= a_q * b;
    if (v2) begin
      acc <= f2 ? shifted : acc + shifted;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign shifted  = ACC_W'(prod >>> FRAC_BITS);
  assign in_range = (&acc[ACC_W-1:VALUE_W-1]) | ~(|acc[ACC_W-1:VALUE_W-1]);

  always_comb begin
    if (in_range) begin
      sat_value = acc[VALUE_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

endmodule

// ===== sv/mm4_seq.sv =====
module mm4_seq import mm4_pkg::*; #(
  parameter int DIM = DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   commit,
  output mm4_ctrl_t              ctrl,
  output logic [$clog2(DIM)-1:0] i,
  output logic [$clog2(DIM)-1:0] j,
  output logic [$clog2(DIM)-1:0] k
);

  localparam int IW = $clog2(DIM);
  localparam logic [IW-1:0] KMAX = IW'(DIM - 1);

  mm4_state_t    state, state_next;
  logic [IW-1:0] i_next, j_next, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (commit) state_next = ST_LOAD;
      ST_LOAD:   if (k == KMAX) state_next = ST_ISSUE;
      ST_ISSUE:  if (k == KMAX) state_next = ST_DRAIN1;
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_EMIT;
      ST_EMIT: begin
        if (j != KMAX) begin
          state_next = ST_ISSUE;
        end else if (i != KMAX) begin
          state_next = ST_LOAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    i_next = i;
    j_next = j;
    k_next = k;
    case (state)
      ST_IDLE: begin
        i_next = '0;
        j_next = '0;
        k_next = '0;
      end
      ST_LOAD, ST_ISSUE: k_next = (k == KMAX) ? '0 : k + 1'b1;
      ST_EMIT: begin
        k_next = '0;
        j_next = (j == KMAX) ? '0 : j + 1'b1;
        if (j == KMAX) begin
          i_next = (i == KMAX) ? '0 : i + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ctrl.load      = (state == ST_LOAD);
    ctrl.issue     = (state == ST_ISSUE);
    ctrl.first     = (state == ST_ISSUE) && (k == '0);
    ctrl.emit      = (state == ST_EMIT);
    ctrl.last_elem = (state == ST_EMIT) && (i == KMAX) && (j == KMAX);
    ctrl.busy      = (state != ST_IDLE);
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import mm4_pkg::*;

  localparam int  N_ELEM      = DIM_DEF * DIM_DEF;
  localparam int  RAND_ITEMS  = 400;
  localparam int  TAIL_CYCLES = 50;
  localparam longint SAT_HI   = 2147483647;
  localparam longint SAT_LO   = -SAT_HI - 1;

  typedef struct {
    logic                      mode;
    logic [INDEX_W-1:0]        row;
    logic [INDEX_W-1:0]        col;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    int unsigned               gap;
    bit                        drain;
  } elem_write_t;

  typedef struct {
    logic [INDEX_W-1:0]        row;
    logic [INDEX_W-1:0]        col;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } product_elem_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      mode = MODE_CUR;
  logic [INDEX_W-1:0]        row = '0;
  logic [INDEX_W-1:0]        col = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      last = 1'b0;
  logic                      out_valid;
  logic [INDEX_W-1:0]        out_row;
  logic [INDEX_W-1:0]        out_col;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;

  matrix4_multiply_accumulate dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .row       (row),
    .col       (col),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  // Predictor state: current transform and operand matrices, row-major
  logic signed [VALUE_W-1:0] cur_mat [N_ELEM];
  logic signed [VALUE_W-1:0] opr_mat [N_ELEM];
  product_elem_t             product_q [$];
  elem_write_t               write_q [$];

  int unsigned items_taken = 0;
  int unsigned commit_cnt  = 0;
  int unsigned elem_cnt    = 0;
  int unsigned sat_cnt     = 0;
  int unsigned fail_cnt    = 0;
  int unsigned calm_left   = 0;

  task automatic apply_write(input elem_write_t it);
    logic signed [VALUE_W-1:0] prod [N_ELEM];
    longint                    acc;
    product_elem_t             pe;
    int                        idx;
    idx = it.row * DIM_DEF + it.col;
    if (it.mode == MODE_CUR) cur_mat[idx] = it.value;
    else opr_mat[idx] = it.value;
    if (it.mode == MODE_OPR && it.last) begin
      for (int i = 0; i < DIM_DEF; i++) begin
        for (int j = 0; j < DIM_DEF; j++) begin
          acc = 0;
          // floor of each exact product, then saturate the exact sum
          for (int k = 0; k < DIM_DEF; k++)
            acc += (longint'(cur_mat[i*DIM_DEF+k]) * longint'(opr_mat[k*DIM_DEF+j]))
                   >>> FRAC_BITS_DEF;
          if (acc > SAT_HI) begin
            prod[i*DIM_DEF+j] = SAT_HI[VALUE_W-1:0];
            sat_cnt++;
          end else if (acc < SAT_LO) begin
            prod[i*DIM_DEF+j] = SAT_LO[VALUE_W-1:0];
            sat_cnt++;
          end else begin
            prod[i*DIM_DEF+j] = acc[VALUE_W-1:0];
          end
        end
      end
      for (int n = 0; n < N_ELEM; n++) begin
        cur_mat[n] = prod[n];
        pe.row   = INDEX_W'(n / DIM_DEF);
        pe.col   = INDEX_W'(n % DIM_DEF);
        pe.value = prod[n];
        pe.last  = (n == N_ELEM - 1);
        product_q.push_back(pe);
      end
      commit_cnt++;
    end
  endtask

  // Monitor and predictor: check results, then record the item taken at this edge
  logic        item_taken = 1'b0;
  elem_write_t seen;

  always @(posedge clk) begin
    product_elem_t want;
    if (rst) begin
      for (int n = 0; n < N_ELEM; n++)
        cur_mat[n] = (n % (DIM_DEF + 1) == 0) ? (32'sd1 <<< FRAC_BITS_DEF) : '0;
      item_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (product_q.size() == 0) begin
          $error("product element with nothing expected: row %0d col %0d value %0d",
                 out_row, out_col, out_value);
          fail_cnt++;
        end else begin
          want = product_q.pop_front();
          elem_cnt++;
          if (out_row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, out_row);
            fail_cnt++;
          end
          if (out_col !== want.col) begin
            $error("out_col: expected %0d, actual %0d", want.col, out_col);
            fail_cnt++;
          end
          if (out_value !== want.value) begin
            $error("out_value: expected %0d, actual %0d", want.value, out_value);
            fail_cnt++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, actual %0d", want.last, out_last);
            fail_cnt++;
          end
        end
      end
      item_taken <= start && !busy;
      if (start && !busy) begin
        seen.mode  = mode;
        seen.row   = row;
        seen.col   = col;
        seen.value = value;
        seen.last  = last;
        apply_write(seen);
        items_taken++;
      end
    end
  end

  // Driver: idle for each item's gap, then hold the item until taken
  bit          holding  = 1'b0;
  int unsigned idle_cnt = 0;
  elem_write_t drv_item;

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (holding && item_taken) holding = 1'b0;
      // a draining item waits for every product element to come back
      if (!holding && write_q.size() > 0 &&
          !(write_q[0].drain && product_q.size() != 0)) begin
        if (idle_cnt < write_q[0].gap) begin
          idle_cnt++;
        end else begin
          drv_item = write_q.pop_front();
          holding  = 1'b1;
          idle_cnt = 0;
        end
      end
      start <= holding;
      if (holding) begin
        mode  <= drv_item.mode;
        row   <= drv_item.row;
        col   <= drv_item.col;
        value <= drv_item.value;
        last  <= drv_item.last;
      end
    end
  end

  task automatic push_write(input logic m, input int r, input int c,
                            input logic signed [VALUE_W-1:0] v, input logic l,
                            input bit drain);
    elem_write_t it;
    it.mode  = m;
    it.row   = INDEX_W'(r);
    it.col   = INDEX_W'(c);
    it.value = v;
    it.last  = l;
    it.drain = drain;
    // alternate idle stretches with back-to-back runs
    if (calm_left == 0 && $urandom_range(0, 7) == 0) calm_left = $urandom_range(15, 40);
    if (calm_left > 0) begin
      it.gap = 0;
      calm_left--;
    end else begin
      it.gap = $urandom_range(0, 6);
    end
    write_q.push_back(it);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] edges [6];
    edges = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000,
              32'shFFFF_FFFF, 32'sh0001_0000, 32'shFFFF_0000};
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return edges[$urandom_range(0, 5)];
      default: return $urandom_range(0, 32'h0008_0000) - 32'sh0004_0000;
    endcase
  endfunction

  initial begin
    logic signed [VALUE_W-1:0] opr_seed [N_ELEM];
    int                        n_rand;
    int                        n_cur;
    int                        n_opr;
    logic                      m;

    // Fill the operand matrix first so no commit ever reads an unwritten entry;
    // against the identity the first commit returns the operand unchanged.
    opr_seed = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh0000_0001,
                 32'sh0001_0000, 32'sh0000_0000, 32'shFFFF_0000, 32'sh5555_AAAA,
                 32'sh0002_8000, 32'shFFFE_8000, 32'shAAAA_5555, 32'sh0000_FFFF,
                 32'sh0001_0000, 32'sh7FFF_0000, 32'sh8000_FFFF, 32'sh0001_0000};
    for (int n = 0; n < N_ELEM; n++)
      push_write(MODE_OPR, n / DIM_DEF, n % DIM_DEF, opr_seed[n], n == N_ELEM - 1, 1'b0);
    // last with mode 0 only writes; drain the first product before it
    push_write(MODE_CUR, 1, 0, 32'sh8000_0000, 1'b1, 1'b1);
    push_write(MODE_CUR, 0, 0, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    // both saturation directions in column 0
    push_write(MODE_OPR, 0, 0, 32'sh7FFF_FFFF, 1'b1, 1'b0);
    push_write(MODE_CUR, 3, 3, 32'sh8000_0000, 1'b0, 1'b0);
    push_write(MODE_OPR, 3, 3, 32'sh8000_0000, 1'b1, 1'b1);

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        n_cur = ($urandom_range(0, 7) == 0) ? N_ELEM : $urandom_range(0, 3);
        for (int n = 0; n < n_cur; n++) begin
          if (n_cur == N_ELEM)
            push_write(MODE_CUR, n / DIM_DEF, n % DIM_DEF, pick_value(),
                       1'($urandom_range(0, 1)), 1'b0);
          else
            push_write(MODE_CUR, $urandom_range(0, 3), $urandom_range(0, 3),
                       pick_value(), 1'($urandom_range(0, 1)), 1'b0);
        end
        n_opr = $urandom_range(0, 6);
        for (int n = 0; n < n_opr; n++)
          push_write(MODE_OPR, $urandom_range(0, 3), $urandom_range(0, 3),
                     pick_value(), 1'b0, 1'b0);
        push_write(MODE_OPR, $urandom_range(0, 3), $urandom_range(0, 3), pick_value(),
                   1'b1, $urandom_range(0, 39) == 0);
        n_rand += n_cur + n_opr + 1;
      end else begin
        // noise: any mode, any index, full-range values
        repeat ($urandom_range(1, 4)) begin
          m = $urandom_range(0, 1) ? MODE_OPR : MODE_CUR;
          push_write(m, $urandom_range(0, 3), $urandom_range(0, 3), $urandom,
                     (m == MODE_CUR) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) == 0),
                     $urandom_range(0, 39) == 0);
          n_rand++;
        end
      end
    end

    @(negedge rst);
    while (write_q.size() != 0 || holding) @(posedge clk);
    while (product_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d element writes and %0d matrix commits", items_taken, commit_cnt);
    $display("Checked %0d product elements, %0d of them saturated", elem_cnt, sat_cnt);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== matrix4_multiply_accumulate.f =====
sv/mm4_pkg.sv
sv/mm4_ram.sv
sv/mm4_mac.sv
sv/mm4_seq.sv
sv/matrix4_multiply_accumulate.sv
dv/testbench.sv
